FILE: sv/truncated_poisson_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Truncated Poisson sampler assertion macros
// Shared property shapes for the cell chain and the selection unit.
// ----------------------------------------------------------------------------
`ifndef TRUNCATED_POISSON_SAMPLER_UNIT_MACROS_SVH
`define TRUNCATED_POISSON_SAMPLER_UNIT_MACROS_SVH
// Consequent checked in the same cycle as the antecedent; off during reset.
`define TPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent checked in the cycle after the antecedent; off during reset.
`define TPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: sv/tps_pkg.sv
// ----------------------------------------------------------------------------
// Truncated Poisson sampler package
// Widths, the reciprocal table for the per-cell divisors and the word that
// travels down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

	// Fixed field widths and sizing constants.
	localparam int UPPER_LIMIT     = 8;
	localparam int FRAC_BITS       = 16;
	localparam int LAMBDA_INT_BITS = 6;
	localparam int LAMBDA_BITS     = FRAC_BITS + LAMBDA_INT_BITS;
	localparam int UNIFORM_BITS    = 32;
	localparam int SAMPLE_BITS     = 4;

	// Upper bound on the bits of any weight: w_j < 2^(FRAC + 6j) / j!, with
	// log2(j!) bounded below by the sum of floor(log2 i).
	function automatic int weight_bits_f();
		int best;
		int lg;
		int cur;
		int j;
		best = FRAC_BITS + 1;
		lg   = 0;
		for (j = 1; j <= UPPER_LIMIT; j++) begin
			lg  = lg + $clog2(j + 1) - 1;
			cur = FRAC_BITS + LAMBDA_INT_BITS * j - lg + 1;
			if (cur > best) begin
				best = cur;
			end
		end
		return best;
	endfunction

	localparam int W_BITS   = weight_bits_f();
	localparam int C_BITS   = W_BITS + $clog2(UPPER_LIMIT + 1);
	localparam int P_BITS   = W_BITS + LAMBDA_BITS;
	localparam int X_BITS   = P_BITS - FRAC_BITS;
	localparam int IDX_BITS = $clog2(UPPER_LIMIT + 1);
	localparam int CNT_BITS = $clog2(UPPER_LIMIT + 2);

	// Division by a small constant d as a multiply by ceil(2^S / d), where
	// S = X_BITS + log2 bound of the largest divisor. Exact for x < 2^X_BITS.
	localparam int DIV_LOG   = $clog2(UPPER_LIMIT);
	localparam int DIV_SHIFT = X_BITS + DIV_LOG;
	localparam int M_BITS    = DIV_SHIFT + 1;
	localparam int Q_BITS    = X_BITS + M_BITS;

	// Operand splits that keep each partial product near 32 by 32 bits.
	localparam int W_LO = W_BITS / 2;
	localparam int W_HI = W_BITS - W_LO;
	localparam int X_LO = X_BITS / 2;
	localparam int X_HI = X_BITS - X_LO;
	localparam int M_LO = M_BITS / 2;
	localparam int M_HI = M_BITS - M_LO;
	localparam int C_LO = C_BITS / 2;
	localparam int C_HI = C_BITS - C_LO;

	localparam int LHS_BITS = C_BITS + UNIFORM_BITS;

	localparam logic [127:0] DIV_ONE = 128'd1 << DIV_SHIFT;

	// Reciprocals for divisors one through fifteen; entry zero is unused.
	localparam logic [M_BITS-1:0] RECIP [16] = '{
		'0,
		M_BITS'((DIV_ONE + 128'd0) / 128'd1),
		M_BITS'((DIV_ONE + 128'd1) / 128'd2),
		M_BITS'((DIV_ONE + 128'd2) / 128'd3),
		M_BITS'((DIV_ONE + 128'd3) / 128'd4),
		M_BITS'((DIV_ONE + 128'd4) / 128'd5),
		M_BITS'((DIV_ONE + 128'd5) / 128'd6),
		M_BITS'((DIV_ONE + 128'd6) / 128'd7),
		M_BITS'((DIV_ONE + 128'd7) / 128'd8),
		M_BITS'((DIV_ONE + 128'd8) / 128'd9),
		M_BITS'((DIV_ONE + 128'd9) / 128'd10),
		M_BITS'((DIV_ONE + 128'd10) / 128'd11),
		M_BITS'((DIV_ONE + 128'd11) / 128'd12),
		M_BITS'((DIV_ONE + 128'd12) / 128'd13),
		M_BITS'((DIV_ONE + 128'd13) / 128'd14),
		M_BITS'((DIV_ONE + 128'd14) / 128'd15)
	};

	// Cumulative sums c_0 .. c_UPPER_LIMIT, filled in as the word moves on.
	typedef logic [UPPER_LIMIT:0][C_BITS-1:0] cum_vec_t;

	// Word handed from cell to cell: w is the newest weight, acc the sum of
	// all weights before it.
	typedef struct packed {
		logic                    vld;
		logic [LAMBDA_BITS-1:0]  lam;
		logic [UNIFORM_BITS-1:0] u;
		logic [W_BITS-1:0]       w;
		logic [C_BITS-1:0]       acc;
		cum_vec_t                cum;
	} cell_word_t;

endpackage

`default_nettype wire

FILE: sv/tps_cell.sv
// ----------------------------------------------------------------------------
// Truncated Poisson sampler weight cell
// Four-stage cell: folds the incoming weight into the running sum and forms
// the next weight w_j = floor(floor(w_(j-1) * lambda / 2^FRAC) / j).
// ----------------------------------------------------------------------------
`default_nettype none
`include "truncated_poisson_sampler_unit_macros.svh"

module tps_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [tps_pkg::IDX_BITS-1:0] idx,
	input  wire tps_pkg::cell_word_t          wi,
	output tps_pkg::cell_word_t               wo
);
	import tps_pkg::*;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [LAMBDA_BITS-1:0]        lam_s1, lam_s2, lam_s3, lam_s4;
	logic [UNIFORM_BITS-1:0]       u_s1, u_s2, u_s3, u_s4;
	logic [C_BITS-1:0]             acc_s1, acc_s2, acc_s3, acc_s4;
	cum_vec_t                      cum_s1, cum_s2, cum_s3, cum_s4;
	logic [W_LO+LAMBDA_BITS-1:0]   ppl_s1;
	logic [W_HI+LAMBDA_BITS-1:0]   pph_s1;
	logic [X_BITS-1:0]             x_s2;
	logic [X_LO+M_LO-1:0]          q_ll_s3;
	logic [X_LO+M_HI-1:0]          q_lh_s3;
	logic [X_HI+M_LO-1:0]          q_hl_s3;
	logic [X_HI+M_HI-1:0]          q_hh_s3;
	logic [W_BITS-1:0]             w_s4;

	logic [C_BITS-1:0]             acc_new;
	cum_vec_t                      cum_upd;
	logic [W_LO+LAMBDA_BITS-1:0]   ppl;
	logic [W_HI+LAMBDA_BITS-1:0]   pph;
	logic [P_BITS-1:0]             prod;
	logic [M_BITS-1:0]             recip;
	logic [X_LO+M_LO-1:0]          q_ll;
	logic [X_LO+M_HI-1:0]          q_lh;
	logic [X_HI+M_LO-1:0]          q_hl;
	logic [X_HI+M_HI-1:0]          q_hh;
	logic [Q_BITS-1:0]             qsum;

	// Stage 1 logic: running sum, its slot in the table, and the weight
	// times lambda as two partial products.
	always_comb begin
		acc_new = wi.acc + C_BITS'(wi.w);
		cum_upd = wi.cum;
		for (int k = 0; k <= UPPER_LIMIT; k++) begin
			if (IDX_BITS'(k + 1) == idx) begin
				cum_upd[k] = acc_new;
			end
		end
		ppl = (W_LO + LAMBDA_BITS)'(wi.w[W_LO-1:0]) * (W_LO + LAMBDA_BITS)'(wi.lam);
		pph = (W_HI + LAMBDA_BITS)'(wi.w[W_BITS-1:W_LO]) * (W_HI + LAMBDA_BITS)'(wi.lam);
	end

	// Stage 2 logic: recombine the product and drop the fraction bits.
	assign prod = P_BITS'(ppl_s1) + (P_BITS'(pph_s1) << W_LO);

	// Stage 3 logic: quotient by the cell's divisor via its reciprocal.
	assign recip = RECIP[idx];

	always_comb begin
		q_ll = (X_LO + M_LO)'(x_s2[X_LO-1:0]) * (X_LO + M_LO)'(recip[M_LO-1:0]);
		q_lh = (X_LO + M_HI)'(x_s2[X_LO-1:0]) * (X_LO + M_HI)'(recip[M_BITS-1:M_LO]);
		q_hl = (X_HI + M_LO)'(x_s2[X_BITS-1:X_LO]) * (X_HI + M_LO)'(recip[M_LO-1:0]);
		q_hh = (X_HI + M_HI)'(x_s2[X_BITS-1:X_LO]) * (X_HI + M_HI)'(recip[M_BITS-1:M_LO]);
	end

	// Stage 4 logic: sum the partial products and keep the quotient bits.
	assign qsum = Q_BITS'(q_ll_s3) + (Q_BITS'(q_lh_s3) << M_LO) +
		(Q_BITS'(q_hl_s3) << X_LO) + (Q_BITS'(q_hh_s3) << (X_LO + M_LO));

	// Valid bits of the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= wi.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Payload registers of the four stages.
	always_ff @(posedge clk) begin
		lam_s1  <= wi.lam;
		u_s1    <= wi.u;
		acc_s1  <= acc_new;
		cum_s1  <= cum_upd;
		ppl_s1  <= ppl;
		pph_s1  <= pph;

		lam_s2  <= lam_s1;
		u_s2    <= u_s1;
		acc_s2  <= acc_s1;
		cum_s2  <= cum_s1;
		x_s2    <= prod[FRAC_BITS +: X_BITS];

		lam_s3  <= lam_s2;
		u_s3    <= u_s2;
		acc_s3  <= acc_s2;
		cum_s3  <= cum_s2;
		q_ll_s3 <= q_ll;
		q_lh_s3 <= q_lh;
		q_hl_s3 <= q_hl;
		q_hh_s3 <= q_hh;

		lam_s4  <= lam_s3;
		u_s4    <= u_s3;
		acc_s4  <= acc_s3;
		cum_s4  <= cum_s3;
		w_s4    <= qsum[DIV_SHIFT +: W_BITS];
	end

	// Word for the next cell.
	always_comb begin
		wo.vld = vld_s4;
		wo.lam = lam_s4;
		wo.u   = u_s4;
		wo.w   = w_s4;
		wo.acc = acc_s4;
		wo.cum = cum_s4;
	end

	// The running sum must never wrap.
	`TPS_ASSERT_NEXT(a_acc_no_wrap, wi.vld, acc_s1 >= $past(wi.acc), "running sum wrapped")
	// A zero rate leaves every weight past the first at zero.
	`TPS_ASSERT_NOW(a_zero_rate, vld_s4 && (lam_s4 == '0), w_s4 == '0, "weight nonzero at zero rate")
	// A word leaves the cell only after passing stages s1, s2, s3 and s4 in turn.
	`TPS_ASSERT_NOW(a_depth, vld_s4, $past(wi.vld, 4), "word left the cell out of step")

endmodule

`default_nettype wire

FILE: sv/tps_select.sv
// ----------------------------------------------------------------------------
// Truncated Poisson sampler selection unit
// Closes the last cumulative sum as the total T, forms u * T and counts the
// cumulative sums that fall below it to give the drawn count plus one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "truncated_poisson_sampler_unit_macros.svh"

module tps_select (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tps_pkg::cell_word_t             wi,
	output logic                                 done,
	output logic [tps_pkg::SAMPLE_BITS-1:0]      sample
);
	import tps_pkg::*;

	logic                           vld_s1, vld_s2, vld_s3;
	logic [UNIFORM_BITS-1:0]        u_s1;
	cum_vec_t                       cum_s1, cum_s2, cum_s3;
	logic [C_LO+UNIFORM_BITS-1:0]   tl_s2;
	logic [C_HI+UNIFORM_BITS-1:0]   th_s2;
	logic [LHS_BITS-1:0]            lhs_s3;
	logic                           done_q;
	logic [SAMPLE_BITS-1:0]         sample_q;

	cum_vec_t                       cum_upd;
	logic [C_LO+UNIFORM_BITS-1:0]   tl;
	logic [C_HI+UNIFORM_BITS-1:0]   th;
	logic [UPPER_LIMIT:0]           gt;
	logic [CNT_BITS-1:0]            cnt;

	// Stage 1 logic: the last cumulative sum is the total.
	always_comb begin
		cum_upd              = wi.cum;
		cum_upd[UPPER_LIMIT] = wi.acc + C_BITS'(wi.w);
	end

	// Stage 2 logic: u times the total as two partial products.
	always_comb begin
		tl = (C_LO + UNIFORM_BITS)'(cum_s1[UPPER_LIMIT][C_LO-1:0]) *
			(C_LO + UNIFORM_BITS)'(u_s1);
		th = (C_HI + UNIFORM_BITS)'(cum_s1[UPPER_LIMIT][C_BITS-1:C_LO]) *
			(C_HI + UNIFORM_BITS)'(u_s1);
	end

	// Stage 4 logic: the sums are nondecreasing, so the smallest index that
	// passes the test equals the number of sums that fail it.
	always_comb begin
		cnt = '0;
		for (int k = 0; k <= UPPER_LIMIT; k++) begin
			gt[k] = lhs_s3 > {cum_s3[k], {UNIFORM_BITS{1'b0}}};
			cnt   = cnt + CNT_BITS'(gt[k]);
		end
	end

	// Valid bits and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= wi.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		u_s1     <= wi.u;
		cum_s1   <= cum_upd;
		cum_s2   <= cum_s1;
		tl_s2    <= tl;
		th_s2    <= th;
		cum_s3   <= cum_s2;
		lhs_s3   <= LHS_BITS'(tl_s2) + (LHS_BITS'(th_s2) << C_LO);
		sample_q <= SAMPLE_BITS'(cnt + CNT_BITS'(1));
	end

	assign done   = done_q;
	assign sample = sample_q;

	// u * T stays below T * 2^32, so the last sum always passes.
	`TPS_ASSERT_NOW(a_lhs_bound, vld_s3,
		lhs_s3 < {cum_s3[UPPER_LIMIT], {UNIFORM_BITS{1'b0}}}, "u*T not below total")
	// Failing sums form a run from index zero.
	`TPS_ASSERT_NOW(a_thermo, vld_s3, ((gt >> 1) & ~gt) == '0, "cumulative sums out of order")
	// The count never passes the upper limit.
	`TPS_ASSERT_NOW(a_cnt_range, vld_s3, cnt <= CNT_BITS'(UPPER_LIMIT), "count beyond limit")

endmodule

`default_nettype wire

FILE: sv/truncated_poisson_sampler_unit.sv
// ----------------------------------------------------------------------------
// Truncated Poisson sampler
// Inverse-CDF draw from a Poisson weight table truncated at UPPER_LIMIT,
// built by a chain of weight cells and a selection unit, without division.
// ----------------------------------------------------------------------------
//   Channel   Handshake        Payload            Direction
//   input     start / busy     lambda, uniform    into the block
//   result    done (strobe)    sample             out of the block
//
// One word is accepted in every cycle; busy stays low.
// Four stages in each weight cell of the chain and four in the selection unit.
// arst_n clears every valid bit and the done strobe; words in flight are lost.
// A result shows for one cycle with done and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module truncated_poisson_sampler_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [tps_pkg::LAMBDA_BITS-1:0]  lambda,
	input  wire logic [tps_pkg::UNIFORM_BITS-1:0] uniform,
	output logic                                  done,
	output logic [tps_pkg::SAMPLE_BITS-1:0]       sample
);
	import tps_pkg::*;

	cell_word_t chain [UPPER_LIMIT+1];

	// The pipeline takes a word in every cycle.
	assign busy = 1'b0;

	// Head of the chain: weight w0 = 1.0, nothing summed yet.
	always_comb begin
		chain[0].vld = start && !busy;
		chain[0].lam = lambda;
		chain[0].u   = uniform;
		chain[0].w   = W_BITS'(1) << FRAC_BITS;
		chain[0].acc = '0;
		chain[0].cum = '0;
	end

	// One cell per weight w1 .. w_UPPER_LIMIT.
	for (genvar g = 1; g <= UPPER_LIMIT; g++) begin : g_cell
		tps_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_BITS'(g)),
			.wi     (chain[g-1]),
			.wo     (chain[g])
		);
	end

	// Total, u * T and the search.
	tps_select u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.wi     (chain[UPPER_LIMIT]),
		.done   (done),
		.sample (sample)
	);

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Truncated Poisson sampler testbench
// Drives rate and uniform words through the start / busy handshake and checks
// each done strobe against a bit-exact inverse-CDF sample computed in 128-bit
// arithmetic. A short directed set is followed by three random phases with
// different sender idle rates.
// ----------------------------------------------------------------------------

module tb_top;
	import tps_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 4 * UPPER_LIMIT + 12;
	localparam int REPORT_MAX   = 10;
	localparam logic [LAMBDA_BITS-1:0]  RATE_MAX = '1;
	localparam logic [LAMBDA_BITS-1:0]  RATE_ONE = LAMBDA_BITS'(1) << FRAC_BITS;
	localparam logic [UNIFORM_BITS-1:0] DRAW_MAX = '1;

	// One word waiting to be offered, with the sender behavior around it.
	typedef struct {
		logic [LAMBDA_BITS-1:0]  lam;
		logic [UNIFORM_BITS-1:0] u;
		int                      idle_pct;
		bit                      drain_first;
	} rate_word_t;

	logic                     clk     = 1'b0;
	logic                     arst_n  = 1'b0;
	logic                     start   = 1'b0;
	logic [LAMBDA_BITS-1:0]   lambda  = '0;
	logic [UNIFORM_BITS-1:0]  uniform = '0;
	logic                     busy;
	logic                     done;
	logic [SAMPLE_BITS-1:0]   sample;

	rate_word_t               pending_words[$];
	logic [SAMPLE_BITS-1:0]   expected_samples[$];
	bit                       word_taken = 1'b0;
	int                       mismatch_cnt = 0;
	int                       stall_cycles = 0;

	truncated_poisson_sampler_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.lambda  (lambda),
		.uniform (uniform),
		.done    (done),
		.sample  (sample)
	);

	// Free-running clock.
	initial begin
		forever #1 clk = ~clk;
	end

	// Builds the truncated weight table, its running sums and the total, then
	// finds the smallest index whose sum covers u * total without dividing.
	function automatic logic [SAMPLE_BITS-1:0] poisson_draw(
		logic [LAMBDA_BITS-1:0] lam, logic [UNIFORM_BITS-1:0] u);
		logic [127:0] weight;
		logic [127:0] scaled_draw;
		logic [127:0] running[UPPER_LIMIT+1];
		int           j;
		int           pick;
		weight     = 128'd1 << FRAC_BITS;
		running[0] = weight;
		for (j = 1; j <= UPPER_LIMIT; j++) begin
			weight     = ((weight * 128'(lam)) >> FRAC_BITS) / 128'(j);
			running[j] = running[j-1] + weight;
		end
		scaled_draw = running[UPPER_LIMIT] * 128'(u);
		// Scan downward so the last hit is the smallest qualifying index.
		pick = UPPER_LIMIT;
		for (j = UPPER_LIMIT; j >= 0; j--) begin
			if (scaled_draw <= (running[j] << UNIFORM_BITS)) begin
				pick = j;
			end
		end
		return SAMPLE_BITS'(pick + 1);
	endfunction

	task automatic add_word(logic [LAMBDA_BITS-1:0] lam, logic [UNIFORM_BITS-1:0] u,
		int idle_pct, bit drain_first);
		rate_word_t w;
		w.lam         = lam;
		w.u           = u;
		w.idle_pct    = idle_pct;
		w.drain_first = drain_first;
		pending_words.push_back(w);
	endtask

	// Random words; the first one waits until every earlier sample is back.
	task automatic add_random_words(int count, int idle_pct);
		logic [LAMBDA_BITS-1:0]  lam;
		logic [UNIFORM_BITS-1:0] u;
		int                      pick;
		int                      i;
		for (i = 0; i < count; i++) begin
			// Most rates sit where every sample value is likely to show up.
			pick = $urandom_range(99);
			if (pick < 50) begin
				lam = LAMBDA_BITS'($urandom_range(0, 12 << FRAC_BITS));
			end else if (pick < 70) begin
				lam = LAMBDA_BITS'($urandom_range(0, 2 << FRAC_BITS));
			end else if (pick < 90) begin
				lam = LAMBDA_BITS'($urandom);
			end else if (pick < 95) begin
				lam = LAMBDA_BITS'($urandom_range(0, 63)) << FRAC_BITS;
			end else begin
				lam = (pick[0]) ? RATE_MAX : '0;
			end
			pick = $urandom_range(99);
			if (pick < 80) begin
				u = $urandom;
			end else if (pick < 90) begin
				u = UNIFORM_BITS'($urandom_range(0, 255));
			end else begin
				u = DRAW_MAX - UNIFORM_BITS'($urandom_range(0, 255));
			end
			add_word(lam, u, idle_pct, i == 0);
		end
	endtask

	// Stimulus: directed corners, then three random phases, then the wrap-up.
	initial begin
		// Zero rate always gives the first sample.
		add_word('0, '0, 7, 1'b0);
		add_word('0, DRAW_MAX, 7, 1'b0);
		add_word('0, 32'h8000_0000, 7, 1'b0);
		// Largest rate, with the draw at both ends and in the middle, so the search reaches the top.
		add_word(RATE_MAX, '0, 7, 1'b0);
		add_word(RATE_MAX, DRAW_MAX, 7, 1'b0);
		add_word(RATE_MAX, 32'h8000_0000, 7, 1'b0);
		// Unit rate and a few whole rates across the range.
		add_word(RATE_ONE, '0, 7, 1'b0);
		add_word(RATE_ONE, DRAW_MAX, 7, 1'b0);
		add_word(RATE_ONE, 32'h5E2D_58D8, 7, 1'b0);
		add_word(LAMBDA_BITS'(RATE_ONE * 4), 32'hC000_0000, 7, 1'b0);
		add_word(LAMBDA_BITS'(RATE_ONE * 8), 32'h4000_0000, 7, 1'b0);
		add_word(LAMBDA_BITS'(RATE_ONE * 12), 32'h7FFF_FFFF, 7, 1'b0);
		add_word(LAMBDA_BITS'(RATE_ONE * 32), 32'h0000_0001, 7, 1'b0);
		add_word(LAMBDA_BITS'(RATE_ONE * 63), 32'hFFFF_FFFE, 7, 1'b0);
		// Tiny fractional rates where only the first weights survive, then larger rates.
		add_word(LAMBDA_BITS'(1), DRAW_MAX, 7, 1'b0);
		add_word(LAMBDA_BITS'(1), '0, 7, 1'b0);
		add_word(LAMBDA_BITS'(16'hFFFF), DRAW_MAX, 7, 1'b0);
		add_word(LAMBDA_BITS'(22'h2AAAAA), 32'hAAAA_AAAA, 7, 1'b0);
		add_word(LAMBDA_BITS'(22'h155555), 32'h5555_5555, 7, 1'b0);
		add_word(LAMBDA_BITS'(RATE_ONE * 2), 32'hF000_0000, 7, 1'b0);
		add_word(LAMBDA_BITS'(RATE_ONE * 6), 32'hFFFF_0000, 7, 1'b0);

		add_random_words(470, 7);
		add_random_words(470, 84);
		add_random_words(460, 0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || start) begin
			@(posedge clk);
		end
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_TICKS) @(posedge clk);

		if (mismatch_cnt == 0 && expected_samples.size() == 0) begin
			$display("truncated_poisson_sampler_unit: match");
		end else begin
			$display("truncated_poisson_sampler_unit: mismatch");
		end
		$finish;
	end

	// Driver: offers the next word once the current one is taken or none is up.
	always @(negedge clk) begin : drive_words
		rate_word_t nxt;
		if (arst_n && (!start || word_taken)) begin
			if (pending_words.size() != 0
				&& !(pending_words[0].drain_first && expected_samples.size() != 0)
				&& $urandom_range(99) >= pending_words[0].idle_pct) begin
				nxt = pending_words.pop_front();
				start   <= 1'b1;
				lambda  <= nxt.lam;
				uniform <= nxt.u;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks each result first, then records the word taken this edge.
	always @(posedge clk) begin : watch_ports
		logic [SAMPLE_BITS-1:0] want;
		word_taken = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (expected_samples.size() == 0) begin
					if (mismatch_cnt < REPORT_MAX) begin
						$display("unexpected sample %0d with no word outstanding", sample);
					end
					mismatch_cnt++;
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want) begin
						if (mismatch_cnt < REPORT_MAX) begin
							$display("sample wrong: expected %0d, got %0d", want, sample);
						end
						mismatch_cnt++;
					end
				end
			end
			if (start && !busy) begin
				expected_samples.push_back(poisson_draw(lambda, uniform));
				word_taken = 1'b1;
			end
		end
	end

	// Watchdog: ends the run when neither side moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= STALL_LIMIT) begin
			$display("truncated_poisson_sampler_unit: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
